/* design/prd_pkg.sv */
// Package for the priority request dispatcher.
// Holds operation and result codes, the queue entry type and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;
	localparam int LIM_W  = 5;

	// Limit value out of reset
	localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd10;

	// Input operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Result kind codes
	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_CANCEL   = 2'd1;
	localparam logic [1:0] KIND_REJECT   = 2'd2;

	// One waiting queue entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} qent_t;

	// Outcome of the shared compare unit
	typedef struct packed {
		logic id_eq;
		logic prio_gt;
	} cmp_res_t;

	// Sequencer states, one-hot
	typedef enum logic [14:0] {
		S_IDLE    = 15'b000000000000001,
		S_ADD_RD  = 15'b000000000000010,
		S_ADD_CMP = 15'b000000000000100,
		S_INS_RD  = 15'b000000000001000,
		S_INS_WR  = 15'b000000000010000,
		S_RM_RD   = 15'b000000000100000,
		S_RM_CMP  = 15'b000000001000000,
		S_DEL_RD  = 15'b000000010000000,
		S_DEL_WR  = 15'b000000100000000,
		S_FL_RD   = 15'b000001000000000,
		S_FL_CMP  = 15'b000010000000000,
		S_FL_DONE = 15'b000100000000000,
		S_EMIT    = 15'b001000000000000,
		S_DISP    = 15'b010000000000000,
		S_POP     = 15'b100000000000000
	} state_t;

endpackage

`default_nettype wire

/* design/prd_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/prd_cmp.sv */
// Shared compare unit: id equality and priority greater-than.
// Depends on prd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prd_cmp
	import prd_pkg::*;
(
	input  wire logic [ID_W-1:0]   a_id,
	input  wire logic [ID_W-1:0]   b_id,
	input  wire logic [PRIO_W-1:0] a_prio,
	input  wire logic [PRIO_W-1:0] b_prio,
	output cmp_res_t               res
);

	always_comb begin
		res.id_eq   = (a_id == b_id);
		res.prio_gt = (a_prio > b_prio);
	end

endmodule

`default_nettype wire

/* design/priority_request_dispatcher.sv */
// Top level of the priority request dispatcher: sequencer, queue and in-flight stores.
// Depends on prd_pkg, prd_ram and prd_cmp.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a priority-ordered waiting queue (lower value first, equal values in
// arrival order) and a set of in-flight ids, and after every input beat moves
// waiting heads in flight while fewer than in_flight_limit are out. One input
// is handled at a time by a sequencer around a single compare unit; in_stall is
// high from the state after the accepted beat until the dispatch pass has ended
// and the sequencer is back in idle. Both stores sit in RAMs with registered
// reads, so each visited queue entry takes a read state and a compare state,
// and each in-flight slot a read state, plus a compare state when valid. An add
// opens a gap when it does not land at the tail; a remove searches the queue
// and then the in-flight slots; each dispatch pops the head and scans the
// in-flight slots. A cancel or reject beat passes through the emit state, and
// every result beat waits in place for as long as the output is stalled. The
// limit register is written through the cfg port, which is always ready; a new
// limit takes effect at the next dispatch decision, also inside a running pass.
module priority_request_dispatcher
	import prd_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int MAX_IN_FLIGHT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [ID_W-1:0]   request_id,
	input  wire logic [PRIO_W-1:0] priority_req,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             kind,
	output logic [ID_W-1:0]        request_id_res,
	output logic                   last,
	// limit register write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [LIM_W-1:0]  in_flight_limit
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int FAW = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
	localparam int FCW = $clog2(MAX_IN_FLIGHT + 1);
	localparam int LW  = (FCW > LIM_W) ? FCW : LIM_W;

	// logical queue position to RAM address
	function automatic logic [QAW-1:0] wrap_idx(input logic [QAW-1:0] base,
		input logic [QCW-1:0] off);
		logic [QAW:0] s;
		s = (QAW+1)'(base) + (QAW+1)'(off);
		if (s >= (QAW+1)'(QUEUE_DEPTH)) begin
			s = s - (QAW+1)'(QUEUE_DEPTH);
		end
		return s[QAW-1:0];
	endfunction

	state_t state_q;

	logic [LIM_W-1:0]  limit_q;
	logic [1:0]        op_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic              disp_q;
	logic              found_q;
	logic              match_q;
	logic              free_found_q;
	logic [FAW-1:0]    free_q;
	logic [1:0]        emit_kind_q;

	logic [QAW-1:0]    head_q;
	logic [QCW-1:0]    wcount_q;
	logic [QCW-1:0]    qi_q;
	logic [QCW-1:0]    pos_q;

	logic [MAX_IN_FLIGHT-1:0] valid_q;
	logic [FCW-1:0]    fcount_q;
	logic [FCW-1:0]    fi_q;

	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	// RAM ports
	logic              q_we;
	logic [QAW-1:0]    q_waddr;
	qent_t             q_wdata;
	logic [QCW-1:0]    q_rd_li;
	logic [QAW-1:0]    q_raddr;
	qent_t             q_rdata;
	logic              f_we;
	logic [ID_W-1:0]   f_rdata;
	logic [FAW-1:0]    fidx;

	cmp_res_t          cmp;
	logic [ID_W-1:0]   cmp_a_id;
	logic              more;
	logic              out_free;

	assign fidx      = fi_q[FAW-1:0];
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// another dispatch is due
	assign more = (wcount_q != '0) && (fcount_q != FCW'(MAX_IN_FLIGHT))
		&& (LW'(fcount_q) < LW'(limit_q));

	// queue RAM port control
	always_comb begin
		case (state_q)
			S_INS_RD: q_rd_li = qi_q - QCW'(1);
			S_DEL_RD: q_rd_li = qi_q + QCW'(1);
			S_DISP:   q_rd_li = '0;
			default:  q_rd_li = qi_q;
		endcase
		q_raddr = wrap_idx(head_q, q_rd_li);
		q_waddr = wrap_idx(head_q, qi_q);
		q_we    = ((state_q == S_INS_RD) && (qi_q == pos_q))
			|| (state_q == S_INS_WR) || (state_q == S_DEL_WR);
		if (state_q == S_INS_RD) begin
			q_wdata.id   = id_q;
			q_wdata.prio = prio_q;
		end else begin
			q_wdata = q_rdata;
		end
	end

	assign f_we = (state_q == S_FL_DONE) && disp_q && !match_q;

	prd_ram #(
		.WIDTH ($bits(qent_t)),
		.DEPTH (QUEUE_DEPTH),
		.AW    (QAW)
	) u_qram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	prd_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_IN_FLIGHT),
		.AW    (FAW)
	) u_fram (
		.clk   (clk),
		.we    (f_we),
		.waddr (free_q),
		.wdata (id_q),
		.raddr (fidx),
		.rdata (f_rdata)
	);

	// one compare unit serves queue and in-flight scans
	assign cmp_a_id = (state_q == S_FL_CMP) ? f_rdata : q_rdata.id;

	prd_cmp u_cmp (
		.a_id   (cmp_a_id),
		.b_id   (id_q),
		.a_prio (q_rdata.prio),
		.b_prio (prio_q),
		.res    (cmp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= LIMIT_RESET;
			op_q         <= OP_ADD;
			id_q         <= '0;
			prio_q       <= '0;
			disp_q       <= 1'b0;
			found_q      <= 1'b0;
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			emit_kind_q  <= KIND_DISPATCH;
			head_q       <= '0;
			wcount_q     <= '0;
			qi_q         <= '0;
			pos_q        <= '0;
			valid_q      <= '0;
			fcount_q     <= '0;
			fi_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= in_flight_limit;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= operation;
						id_q         <= request_id;
						prio_q       <= priority_req;
						disp_q       <= 1'b0;
						found_q      <= 1'b0;
						match_q      <= 1'b0;
						free_found_q <= 1'b0;
						qi_q         <= '0;
						fi_q         <= '0;
						unique case (operation)
							OP_ADD: begin
								if (wcount_q == QCW'(QUEUE_DEPTH)) begin
									emit_kind_q <= KIND_REJECT;
									state_q     <= S_EMIT;
								end else begin
									state_q <= S_ADD_RD;
								end
							end
							OP_REMOVE: state_q <= S_RM_RD;
							OP_FINISH: state_q <= S_FL_RD;
							OP_CLEAR: begin
								wcount_q <= '0;
								valid_q  <= '0;
								fcount_q <= '0;
								state_q  <= S_DISP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// find the insert position
				S_ADD_RD: begin
					if (qi_q == wcount_q) begin
						pos_q   <= qi_q;
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_ADD_CMP;
					end
				end
				S_ADD_CMP: begin
					if (cmp.prio_gt) begin
						pos_q   <= qi_q;
						qi_q    <= wcount_q;
						state_q <= S_INS_RD;
					end else begin
						qi_q    <= qi_q + QCW'(1);
						state_q <= S_ADD_RD;
					end
				end
				// open a gap at the insert position, tail first
				S_INS_RD: begin
					if (qi_q == pos_q) begin
						wcount_q <= wcount_q + QCW'(1);
						state_q  <= S_DISP;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					qi_q    <= qi_q - QCW'(1);
					state_q <= S_INS_RD;
				end
				// search the queue for the id
				S_RM_RD: begin
					if (qi_q == wcount_q) begin
						state_q <= S_FL_RD;
					end else begin
						state_q <= S_RM_CMP;
					end
				end
				S_RM_CMP: begin
					if (cmp.id_eq) begin
						found_q <= 1'b1;
						state_q <= S_DEL_RD;
					end else begin
						qi_q    <= qi_q + QCW'(1);
						state_q <= S_RM_RD;
					end
				end
				// close the gap, head side first
				S_DEL_RD: begin
					if (qi_q + QCW'(1) == wcount_q) begin
						wcount_q <= wcount_q - QCW'(1);
						state_q  <= S_FL_RD;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					qi_q    <= qi_q + QCW'(1);
					state_q <= S_DEL_RD;
				end
				// scan in-flight slots: first match, first free slot
				S_FL_RD: begin
					if (fi_q == FCW'(MAX_IN_FLIGHT)) begin
						state_q <= S_FL_DONE;
					end else if (valid_q[fidx]) begin
						state_q <= S_FL_CMP;
					end else begin
						if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= fidx;
						end
						fi_q <= fi_q + FCW'(1);
					end
				end
				S_FL_CMP: begin
					if (cmp.id_eq) begin
						match_q <= 1'b1;
						state_q <= S_FL_DONE;
					end else begin
						fi_q    <= fi_q + FCW'(1);
						state_q <= S_FL_RD;
					end
				end
				S_FL_DONE: begin
					if (disp_q) begin
						if (!match_q) begin
							valid_q[free_q] <= 1'b1;
							fcount_q        <= fcount_q + FCW'(1);
						end
						emit_kind_q <= KIND_DISPATCH;
						state_q     <= S_EMIT;
					end else begin
						if (match_q) begin
							valid_q[fidx] <= 1'b0;
							fcount_q      <= fcount_q - FCW'(1);
						end
						if ((op_q == OP_REMOVE) && (match_q || found_q)) begin
							emit_kind_q <= KIND_CANCEL;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_DISP;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_DISP;
					end
				end
				// dispatch pass: head read issued here
				S_DISP: begin
					if (more) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					id_q         <= q_rdata.id;
					head_q       <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0
						: head_q + QAW'(1);
					wcount_q     <= wcount_q - QCW'(1);
					disp_q       <= 1'b1;
					match_q      <= 1'b0;
					free_found_q <= 1'b0;
					fi_q         <= '0;
					state_q      <= S_FL_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_DISPATCH;
			out_id_q    <= '0;
			out_last_q  <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
			out_kind_q  <= emit_kind_q;
			out_id_q    <= id_q;
			out_last_q  <= !more;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_kind_q;
	assign request_id_res = out_id_q;
	assign last           = out_last_q;

endmodule

`default_nettype wire

/* design/prd_checker.sv */
// Port-level checker for the priority request dispatcher, bound to the top level.
// Depends on prd_pkg and priority_request_dispatcher.
`timescale 1ns / 1ps
`default_nettype none

module prd_checker
	import prd_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_stall,
	input wire logic            out_valid,
	input wire logic            out_stall,
	input wire logic [1:0]      kind,
	input wire logic [ID_W-1:0] request_id_res,
	input wire logic            last
);

	// an accepted beat occupies the sequencer on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepted beat");

	// a result that is not the final one keeps the input side stalled
	a_stall_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("input open while results still pending");

	// only defined result kinds leave the block
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_DISPATCH || kind == KIND_CANCEL
			|| kind == KIND_REJECT))
		else $error("undefined result kind");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind)
			&& $stable(request_id_res) && $stable(last)))
		else $error("stalled result beat changed");

endmodule

bind priority_request_dispatcher prd_checker u_prd_checker (.*);

`default_nettype wire
